// ----- src/assert_macros.svh -----
// Assertion macros shared by the sphere grid index generator RTL.
// Each macro expects clk and rst_n in scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sgti_pkg.sv -----
// Shared types and constants of the sphere grid triangle index generator.
// No dependencies.
package sgti_pkg;

    localparam int CNT_W = 9;   // slice/stack count register width
    localparam int VTX_W = 16;  // vertex index width

    localparam int SLICE_LO = 3;
    localparam int STACK_LO = 2;

    // configuration register indexes
    localparam logic REG_SLICE_COUNT = 1'b0;
    localparam logic REG_STACK_COUNT = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
        logic             last_triangle;
    } face_t;

endpackage

// ----- src/sgti_walker.sv -----
// Mesh walker: section/row/column counters and the triangle index math.
// Depends on sgti_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgti_walker
    import sgti_pkg::*;
#(
    parameter int MAX_SLICES = 256,
    parameter int MAX_STACKS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             restart,
    input  logic [CNT_W-1:0] slice_count,
    input  logic [CNT_W-1:0] stack_count,
    output face_t            face,
    output logic             produce
);

    localparam int CNT_MAX  = 2**CNT_W - 1;
    localparam int SLICE_HI = (MAX_SLICES > CNT_MAX) ? CNT_MAX : MAX_SLICES;
    localparam int STACK_HI = (MAX_STACKS > CNT_MAX) ? CNT_MAX : MAX_STACKS;

    typedef enum logic [1:0] {
        SEC_TOP,
        SEC_MID,
        SEC_BOT,
        SEC_DONE
    } section_t;

    section_t         section_reg, section_next, sec_c;
    logic [CNT_W-1:0] row_reg, row_next, row_c;
    logic [CNT_W-1:0] col_reg, col_next, col_c;
    logic             second_reg, second_next, second_c;
    logic [VTX_W-1:0] tb_reg, tb_next, tb_c;
    logic [CNT_W-1:0] s_reg, s_next, s_c;
    logic [CNT_W-1:0] t_reg, t_next, t_c;

    logic [CNT_W-1:0] s_clamp, t_clamp, col_inc, col_wrap, row_inc;
    logic             wrap, to_bot;
    logic [VTX_W-1:0] s16, col16, colw16, bb;

    always_comb
    begin
        if (slice_count < CNT_W'(SLICE_LO))
            s_clamp = CNT_W'(SLICE_LO);
        else if (slice_count > CNT_W'(SLICE_HI))
            s_clamp = CNT_W'(SLICE_HI);
        else
            s_clamp = slice_count;

        if (stack_count < CNT_W'(STACK_LO))
            t_clamp = CNT_W'(STACK_LO);
        else if (stack_count > CNT_W'(STACK_HI))
            t_clamp = CNT_W'(STACK_HI);
        else
            t_clamp = stack_count;
    end

    // restart applies to the same beat: the first triangle comes from the fresh state
    always_comb
    begin
        if (restart)
        begin
            sec_c    = SEC_TOP;
            row_c    = '0;
            col_c    = '0;
            second_c = 1'b0;
            tb_c     = VTX_W'(1);
            s_c      = s_clamp;
            t_c      = t_clamp;
        end
        else
        begin
            sec_c    = section_reg;
            row_c    = row_reg;
            col_c    = col_reg;
            second_c = second_reg;
            tb_c     = tb_reg;
            s_c      = s_reg;
            t_c      = t_reg;
        end
    end

    always_comb
    begin
        wrap     = ({1'b0, col_c} + (CNT_W+1)'(1)) >= {1'b0, s_c};
        col_inc  = col_c + CNT_W'(1);
        col_wrap = wrap ? '0 : col_inc;
        row_inc  = row_c + CNT_W'(1);
        to_bot   = {1'b0, row_inc} >= ({1'b0, t_c} - (CNT_W+1)'(2));
        s16      = VTX_W'(s_c);
        col16    = VTX_W'(col_c);
        colw16   = VTX_W'(col_wrap);
        bb       = tb_c + s16;   // next row base, also the south pole in the bottom fan

        section_next = sec_c;
        row_next     = row_c;
        col_next     = col_c;
        second_next  = second_c;
        tb_next      = tb_c;
        s_next       = s_c;
        t_next       = t_c;
        face         = '0;

        unique case (sec_c)
            SEC_TOP:
            begin
                face.vertex_a = '0;
                face.vertex_b = col16 + VTX_W'(1);
                face.vertex_c = colw16 + VTX_W'(1);
                if (wrap)
                begin
                    col_next     = '0;
                    second_next  = 1'b0;
                    tb_next      = VTX_W'(1);
                    row_next     = '0;
                    section_next = (t_c > CNT_W'(2)) ? SEC_MID : SEC_BOT;
                end
                else
                    col_next = col_inc;
            end
            SEC_MID:
            begin
                face.vertex_a = bb + col16;
                face.vertex_b = second_c ? (tb_c + colw16) : (bb + colw16);
                face.vertex_c = second_c ? (tb_c + col16) : (tb_c + colw16);
                if (!second_c)
                    second_next = 1'b1;
                else
                begin
                    second_next = 1'b0;
                    if (wrap)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                        tb_next  = bb;
                        if (to_bot)
                            section_next = SEC_BOT;
                    end
                    else
                        col_next = col_inc;
                end
            end
            SEC_BOT:
            begin
                face.vertex_a = bb;
                face.vertex_b = bb - VTX_W'(1) - col16;
                face.vertex_c = wrap ? (bb - VTX_W'(1)) : (bb - VTX_W'(2) - col16);
                if (wrap)
                begin
                    face.last_triangle = 1'b1;
                    section_next       = SEC_DONE;
                    col_next           = '0;
                end
                else
                    col_next = col_inc;
            end
            SEC_DONE:
            begin
                face = '0;
            end
        endcase

        produce = advance && (sec_c != SEC_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= SEC_DONE;
            row_reg     <= '0;
            col_reg     <= '0;
            second_reg  <= 1'b0;
            tb_reg      <= VTX_W'(1);
            s_reg       <= CNT_W'(SLICE_LO);
            t_reg       <= CNT_W'(STACK_LO);
        end
        else if (advance)
        begin
            section_reg <= section_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            second_reg  <= second_next;
            tb_reg      <= tb_next;
            s_reg       <= s_next;
            t_reg       <= t_next;
        end
    end

    `SGTI_ASSERT_NOW(a_done_silent, advance && !restart && section_reg == SEC_DONE,
        !produce, "beat produced a triangle with no mesh active")
    `SGTI_ASSERT_NOW(a_mid_needs_rows, section_reg == SEC_MID,
        t_reg > CNT_W'(2), "middle rows entered with fewer than three stacks")
    `SGTI_ASSERT_NOW(a_col_range, 1'b1,
        col_reg < s_reg, "column index beyond slice count")
    `SGTI_ASSERT_NEXT(a_last_ends, produce && face.last_triangle,
        section_reg == SEC_DONE, "mesh still active after last triangle")

endmodule

// ----- src/sgti_out_stage.sv -----
// Result register of the triangle index generator: holds one beat for the sink.
// Depends on sgti_pkg.
module sgti_out_stage
    import sgti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  face_t            face,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             busy,
    output logic [VTX_W-1:0] vertex_a,
    output logic [VTX_W-1:0] vertex_b,
    output logic [VTX_W-1:0] vertex_c,
    output logic             last_triangle
);

    logic  valid_reg, valid_next;
    face_t face_reg;

    // full and held by the sink: upstream must wait
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (busy)
            valid_next = 1'b1;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            face_reg <= face;
    end

    assign out_valid     = valid_reg;
    assign vertex_a      = face_reg.vertex_a;
    assign vertex_b      = face_reg.vertex_b;
    assign vertex_c      = face_reg.vertex_c;
    assign last_triangle = face_reg.last_triangle;

endmodule

// ----- src/sphere_grid_triangle_index_generator.sv -----
// Channel  | Signals                                        | Beat moves when
// request  | in_valid, in_stall, restart                    | in_valid && !in_stall
// triangle | out_valid, out_stall, vertex_a/b/c, last_tri.. | out_valid && !out_stall
// config   | cfg_write, cfg_index, cfg_data                 | cfg_write
// One triangle per cycle while in_stall is low; result appears the cycle after the request beat.
// Latency is set by the single result register behind the walker's index math.
// rst_n clears the walker to no active mesh and the result register to empty.
// in_stall follows out_stall only while a result is held; no clearing pass.
// Depends on sgti_pkg, sgti_walker, sgti_out_stage.
module sphere_grid_triangle_index_generator
    import sgti_pkg::*;
#(
    parameter int MAX_SLICES = 256,
    parameter int MAX_STACKS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VTX_W-1:0] vertex_a,
    output logic [VTX_W-1:0] vertex_b,
    output logic [VTX_W-1:0] vertex_c,
    output logic             last_triangle
);

    logic [CNT_W-1:0] slice_count_reg, stack_count_reg;
    logic             accept, produce, busy;
    face_t            face;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= CNT_W'(SLICE_LO);
            stack_count_reg <= CNT_W'(STACK_LO);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLICE_COUNT: slice_count_reg <= cfg_data;
                REG_STACK_COUNT: stack_count_reg <= cfg_data;
                default:         slice_count_reg <= slice_count_reg;
            endcase
        end
    end

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    sgti_walker #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_STACKS (MAX_STACKS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .restart     (restart),
        .slice_count (slice_count_reg),
        .stack_count (stack_count_reg),
        .face        (face),
        .produce     (produce)
    );

    sgti_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (produce),
        .face          (face),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .busy          (busy),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .last_triangle (last_triangle)
    );

endmodule
